// File: hw/rtl/cmee_pkg.sv
// shared types and constants for the cursor move escape encoder
package cmee_pkg;

	// byte codes used in the emitted sequences
	localparam logic [7:0] CH_BS   = 8'h08;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_RI   = 8'h4D;
	localparam logic [7:0] FIN_CUU = 8'h41;
	localparam logic [7:0] FIN_CUD = 8'h42;
	localparam logic [7:0] FIN_CUF = 8'h43;
	localparam logic [7:0] FIN_CUB = 8'h44;
	localparam logic [7:0] FIN_CNL = 8'h45;
	localparam logic [7:0] FIN_CPL = 8'h46;
	localparam logic [7:0] FIN_CHA = 8'h47;
	localparam logic [7:0] FIN_CUP = 8'h48;
	localparam logic [3:0] DIGIT_HI = 4'h3;

	// sequence segments, emitted from lowest index to highest
	localparam int SEG_PRE   = 0;
	localparam int SEG_ESC   = 1;
	localparam int SEG_LBR   = 2;
	localparam int SEG_N1    = 3;
	localparam int SEG_SEMI  = 4;
	localparam int SEG_N2    = 5;
	localparam int SEG_FIN   = 6;
	localparam int SEG_RIESC = 7;
	localparam int SEG_RIM   = 8;
	localparam int SEG_LF    = 9;
	localparam int SEG_N     = 10;

	// x / 10 == (x * 52429) >> 19 for every x below 2^18
	localparam int unsigned DIV10_MUL   = 52429;
	localparam int unsigned DIV10_SHIFT = 19;

	typedef struct packed {
		logic [SEG_N-1:0] pend;
		logic [7:0]       pre_byte;
		logic [7:0]       fin_byte;
	} cmee_ctl_t;

endpackage

// File: hw/rtl/cmee_plan.sv
// move classification: picks the sequence segments and the counts to print
module cmee_plan #(
	parameter int CB = 12,
	parameter int NW = 13
) (
	input  logic [CB-1:0]         cur_row,
	input  logic [CB-1:0]         cur_col,
	input  logic                  cur_col_known,
	input  logic [CB-1:0]         want_row,
	input  logic [CB-1:0]         want_col,
	output cmee_pkg::cmee_ctl_t   ctl,
	output logic [NW-1:0]         n1,
	output logic [NW-1:0]         n2
);

	logic [NW-1:0] cr_x, cc_x, wr_x, wc_x;
	logic          row_eq, col_same, down1, up1, wc_zero, wr_zero;
	logic [cmee_pkg::SEG_N-1:0] col_pend;
	logic [7:0]    col_pre, col_fin;
	logic [NW-1:0] col_n;

	assign cr_x = {1'b0, cur_row};
	assign cc_x = {1'b0, cur_col};
	assign wr_x = {1'b0, want_row};
	assign wc_x = {1'b0, want_col};

	assign row_eq   = cur_row == want_row;
	assign col_same = cur_col_known && (cur_col == want_col);
	assign down1    = wr_x == cr_x + NW'(1);
	assign up1      = wr_x + NW'(1) == cr_x;
	assign wc_zero  = want_col == '0;
	assign wr_zero  = want_row == '0;

	// move on the current row only
	always_comb begin
		col_pend = '0;
		col_pre  = cmee_pkg::CH_CR;
		col_fin  = cmee_pkg::FIN_CHA;
		col_n    = wc_x + NW'(1);
		if (wc_zero) begin
			col_pend[cmee_pkg::SEG_PRE] = 1'b1;
		end else if (!cur_col_known) begin
			col_pend[cmee_pkg::SEG_ESC] = 1'b1;
			col_pend[cmee_pkg::SEG_LBR] = 1'b1;
			col_pend[cmee_pkg::SEG_N1]  = 1'b1;
			col_pend[cmee_pkg::SEG_FIN] = 1'b1;
		end else if (wc_x + NW'(1) == cc_x) begin
			col_pend[cmee_pkg::SEG_PRE] = 1'b1;
			col_pre = cmee_pkg::CH_BS;
		end else begin
			col_pend[cmee_pkg::SEG_ESC] = 1'b1;
			col_pend[cmee_pkg::SEG_LBR] = 1'b1;
			col_pend[cmee_pkg::SEG_N1]  = 1'b1;
			col_pend[cmee_pkg::SEG_FIN] = 1'b1;
			if (want_col < cur_col) begin
				col_fin = cmee_pkg::FIN_CUB;
				col_n   = cc_x - wc_x;
			end else begin
				col_fin = cmee_pkg::FIN_CUF;
				col_n   = wc_x - cc_x;
			end
		end
	end

	always_comb begin
		ctl.pend     = '0;
		ctl.pre_byte = cmee_pkg::CH_CR;
		ctl.fin_byte = cmee_pkg::FIN_CUP;
		n1           = wr_x + NW'(1);
		n2           = wc_x + NW'(1);
		if (row_eq && col_same) begin
			ctl.pend = '0;
		end else if (row_eq) begin
			ctl.pend     = col_pend;
			ctl.pre_byte = col_pre;
			ctl.fin_byte = col_fin;
			n1           = col_n;
		end else if (col_same) begin
			if (down1) begin
				ctl.pend[cmee_pkg::SEG_LF] = 1'b1;
			end else if (up1) begin
				ctl.pend[cmee_pkg::SEG_RIESC] = 1'b1;
				ctl.pend[cmee_pkg::SEG_RIM]   = 1'b1;
			end else begin
				ctl.pend[cmee_pkg::SEG_ESC] = 1'b1;
				ctl.pend[cmee_pkg::SEG_LBR] = 1'b1;
				ctl.pend[cmee_pkg::SEG_N1]  = 1'b1;
				ctl.pend[cmee_pkg::SEG_FIN] = 1'b1;
				if (want_row < cur_row) begin
					ctl.fin_byte = cmee_pkg::FIN_CUU;
					n1           = cr_x - wr_x;
				end else begin
					ctl.fin_byte = cmee_pkg::FIN_CUD;
					n1           = wr_x - cr_x;
				end
			end
		end else if (wc_zero) begin
			if (wr_zero) begin
				// home without counts
				ctl.pend[cmee_pkg::SEG_ESC] = 1'b1;
				ctl.pend[cmee_pkg::SEG_LBR] = 1'b1;
				ctl.pend[cmee_pkg::SEG_FIN] = 1'b1;
			end else if (down1) begin
				ctl.pend[cmee_pkg::SEG_PRE] = 1'b1;
				ctl.pend[cmee_pkg::SEG_LF]  = 1'b1;
			end else if (up1) begin
				ctl.pend[cmee_pkg::SEG_PRE]   = 1'b1;
				ctl.pend[cmee_pkg::SEG_RIESC] = 1'b1;
				ctl.pend[cmee_pkg::SEG_RIM]   = 1'b1;
			end else begin
				ctl.pend[cmee_pkg::SEG_ESC] = 1'b1;
				ctl.pend[cmee_pkg::SEG_LBR] = 1'b1;
				ctl.pend[cmee_pkg::SEG_N1]  = 1'b1;
				ctl.pend[cmee_pkg::SEG_FIN] = 1'b1;
				if (want_row < cur_row) begin
					ctl.fin_byte = cmee_pkg::FIN_CPL;
					n1           = cr_x - wr_x;
				end else begin
					ctl.fin_byte = cmee_pkg::FIN_CNL;
					n1           = wr_x - cr_x;
				end
			end
		end else if (down1 || up1) begin
			// column move first, then the single row step
			ctl.pend     = col_pend;
			ctl.pre_byte = col_pre;
			ctl.fin_byte = col_fin;
			n1           = col_n;
			if (down1) begin
				ctl.pend[cmee_pkg::SEG_LF] = 1'b1;
			end else begin
				ctl.pend[cmee_pkg::SEG_RIESC] = 1'b1;
				ctl.pend[cmee_pkg::SEG_RIM]   = 1'b1;
			end
		end else begin
			ctl.pend[cmee_pkg::SEG_ESC]  = 1'b1;
			ctl.pend[cmee_pkg::SEG_LBR]  = 1'b1;
			ctl.pend[cmee_pkg::SEG_N1]   = 1'b1;
			ctl.pend[cmee_pkg::SEG_SEMI] = 1'b1;
			ctl.pend[cmee_pkg::SEG_N2]   = 1'b1;
			ctl.pend[cmee_pkg::SEG_FIN]  = 1'b1;
		end
	end

endmodule

// File: hw/rtl/cmee_digit_stage.sv
// one decimal digit stage: peels the low digit off both counts
module cmee_digit_stage #(
	parameter int NW   = 13,
	parameter int NDIG = 4,
	parameter int POS  = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  cmee_pkg::cmee_ctl_t      in_ctl,
	input  logic [NW-1:0]            in_v1,
	input  logic [NW-1:0]            in_v2,
	input  logic [NDIG-1:0][3:0]     in_dig1,
	input  logic [NDIG-1:0][3:0]     in_dig2,
	output logic                     out_valid,
	input  logic                     out_ready,
	output cmee_pkg::cmee_ctl_t      out_ctl,
	output logic [NW-1:0]            out_v1,
	output logic [NW-1:0]            out_v2,
	output logic [NDIG-1:0][3:0]     out_dig1,
	output logic [NDIG-1:0][3:0]     out_dig2
);

	localparam int PW = NW + 16;

	logic                 valid_q;
	cmee_pkg::cmee_ctl_t  ctl_q;
	logic [NW-1:0]        v1_q, v2_q;
	logic [NDIG-1:0][3:0] dig1_q, dig2_q;
	logic [PW-1:0]        p1, p2;
	logic [NW-1:0]        q1, q2, r1, r2;
	logic [NDIG-1:0][3:0] dig1_n, dig2_n;

	// divide by ten through a reciprocal multiply
	assign p1 = PW'(in_v1) * PW'(cmee_pkg::DIV10_MUL);
	assign p2 = PW'(in_v2) * PW'(cmee_pkg::DIV10_MUL);
	assign q1 = NW'(p1 >> cmee_pkg::DIV10_SHIFT);
	assign q2 = NW'(p2 >> cmee_pkg::DIV10_SHIFT);
	assign r1 = in_v1 - ((q1 << 3) + (q1 << 1));
	assign r2 = in_v2 - ((q2 << 3) + (q2 << 1));

	always_comb begin
		dig1_n      = in_dig1;
		dig2_n      = in_dig2;
		dig1_n[POS] = r1[3:0];
		dig2_n[POS] = r2[3:0];
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctl_q  <= in_ctl;
			v1_q   <= q1;
			v2_q   <= q2;
			dig1_q <= dig1_n;
			dig2_q <= dig2_n;
		end
	end

	assign out_valid = valid_q;
	assign out_ctl   = ctl_q;
	assign out_v1    = v1_q;
	assign out_v2    = v2_q;
	assign out_dig1  = dig1_q;
	assign out_dig2  = dig2_q;

endmodule

// File: hw/rtl/cmee_serializer.sv
// byte serializer: walks the pending segments of one sequence, one byte a cycle
module cmee_serializer #(
	parameter int NDIG = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cmee_pkg::cmee_ctl_t  in_ctl,
	input  logic [NDIG-1:0][3:0] in_dig1,
	input  logic [NDIG-1:0][3:0] in_dig2,
	output logic                 byte_valid,
	output logic [7:0]           out_byte,
	output logic                 last_byte
);

	localparam int SN    = cmee_pkg::SEG_N;
	localparam int IDX_W = $clog2(NDIG);

	logic [SN-1:0]        pend_q, seg_oh, next_pend;
	logic [7:0]           pre_q, fin_q;
	logic [NDIG-1:0][3:0] dig1_q, dig2_q;
	logic [IDX_W-1:0]     idx1_q, idx2_q, top1, top2;
	logic                 hold1, hold2, take;

	// lowest pending segment is the one on the port
	assign seg_oh = pend_q & (~pend_q + SN'(1));

	assign hold1 = seg_oh[cmee_pkg::SEG_N1] && (idx1_q != '0);
	assign hold2 = seg_oh[cmee_pkg::SEG_N2] && (idx2_q != '0);
	assign next_pend = (hold1 || hold2) ? pend_q : (pend_q & ~seg_oh);

	assign byte_valid = pend_q != '0;
	assign last_byte  = byte_valid && (next_pend == '0);
	assign take       = !byte_valid || last_byte;
	assign in_ready   = take;

	always_comb begin
		if (seg_oh[cmee_pkg::SEG_PRE]) begin
			out_byte = pre_q;
		end else if (seg_oh[cmee_pkg::SEG_ESC] || seg_oh[cmee_pkg::SEG_RIESC]) begin
			out_byte = cmee_pkg::CH_ESC;
		end else if (seg_oh[cmee_pkg::SEG_LBR]) begin
			out_byte = cmee_pkg::CH_LBR;
		end else if (seg_oh[cmee_pkg::SEG_N1]) begin
			out_byte = {cmee_pkg::DIGIT_HI, dig1_q[idx1_q]};
		end else if (seg_oh[cmee_pkg::SEG_SEMI]) begin
			out_byte = cmee_pkg::CH_SEMI;
		end else if (seg_oh[cmee_pkg::SEG_N2]) begin
			out_byte = {cmee_pkg::DIGIT_HI, dig2_q[idx2_q]};
		end else if (seg_oh[cmee_pkg::SEG_FIN]) begin
			out_byte = fin_q;
		end else if (seg_oh[cmee_pkg::SEG_RIM]) begin
			out_byte = cmee_pkg::CH_RI;
		end else begin
			out_byte = cmee_pkg::CH_LF;
		end
	end

	// most significant nonzero digit, no leading zeros
	always_comb begin
		top1 = '0;
		top2 = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (in_dig1[i] != '0) begin
				top1 = IDX_W'(i);
			end
			if (in_dig2[i] != '0) begin
				top2 = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (take) begin
			pend_q <= in_valid ? in_ctl.pend : '0;
		end else begin
			pend_q <= next_pend;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (in_valid) begin
				pre_q  <= in_ctl.pre_byte;
				fin_q  <= in_ctl.fin_byte;
				dig1_q <= in_dig1;
				dig2_q <= in_dig2;
				idx1_q <= top1;
				idx2_q <= top2;
			end
		end else begin
			if (hold1) begin
				idx1_q <= idx1_q - IDX_W'(1);
			end
			if (hold2) begin
				idx2_q <= idx2_q - IDX_W'(1);
			end
		end
	end

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !last_byte |=> byte_valid)
		else $error("sequence broken before its last byte");

	a_last_single: assert property (@(posedge clk) disable iff (!arst_n)
		last_byte |-> $onehot(pend_q))
		else $error("last byte with more segments pending");

	a_load_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> byte_valid)
		else $error("loaded sequence produced no byte");

endmodule

// File: hw/rtl/cursor_move_escape_encoder_core.sv
// top level of the cursor move escape encoder
//
// Usage: drive cur_row, cur_col, cur_col_known, want_row and want_col with
// start high; the move is taken at a rising edge where start is high and busy
// is low. The block answers with the bytes of the terminal sequence that moves
// the cursor, one byte per cycle on out_byte, each marked by byte_valid for one
// cycle, with last_byte on the final byte. A move to the same position with
// cur_col_known high gives no bytes at all.
// The first byte reaches the port through the input register, the classify
// register, one stage per decimal digit, then the serializer register. Every
// later byte follows in the next cycle.
// Throughput: the serializer sends one byte per cycle, so a move of L bytes
// holds it until all L are sent (1 to 2*digits+4 bytes, at most 12 for 12-bit
// coordinates); bytes of consecutive moves follow with no idle cycle when the
// next move waits at the serializer input. busy rises only when every pipeline stage holds a move.
// Reset: arst_n clears all valid flags and the pending segment mask; no bytes
// come out until a move is taken. The receiver has no way to stall the output.
module cursor_move_escape_encoder_core #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [COORD_BITS-1:0] cur_row,
	input  logic [COORD_BITS-1:0] cur_col,
	input  logic                  cur_col_known,
	input  logic [COORD_BITS-1:0] want_row,
	input  logic [COORD_BITS-1:0] want_col,
	output logic                  byte_valid,
	output logic [7:0]            out_byte,
	output logic                  last_byte
);

	localparam int NW   = COORD_BITS + 1;
	localparam int NDIG = (COORD_BITS * 3) / 10 + 1;

	logic                  valid_s1, ready_s1;
	logic [COORD_BITS-1:0] cur_row_s1, cur_col_s1, want_row_s1, want_col_s1;
	logic                  known_s1;

	cmee_pkg::cmee_ctl_t   plan_ctl;
	logic [NW-1:0]         plan_n1, plan_n2;

	logic                  valid_s2;
	cmee_pkg::cmee_ctl_t   ctl_s2;
	logic [NW-1:0]         n1_s2, n2_s2;

	logic [NDIG:0]         st_valid, st_ready;
	cmee_pkg::cmee_ctl_t   st_ctl  [NDIG+1];
	logic [NW-1:0]         st_v1   [NDIG+1];
	logic [NW-1:0]         st_v2   [NDIG+1];
	logic [NDIG-1:0][3:0]  st_dig1 [NDIG+1];
	logic [NDIG-1:0][3:0]  st_dig2 [NDIG+1];

	assign busy = valid_s1 && !ready_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!busy) begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cur_row_s1  <= cur_row;
			cur_col_s1  <= cur_col;
			known_s1    <= cur_col_known;
			want_row_s1 <= want_row;
			want_col_s1 <= want_col;
		end
	end

	cmee_plan #(
		.CB(COORD_BITS),
		.NW(NW)
	) u_plan (
		.cur_row      (cur_row_s1),
		.cur_col      (cur_col_s1),
		.cur_col_known(known_s1),
		.want_row     (want_row_s1),
		.want_col     (want_col_s1),
		.ctl          (plan_ctl),
		.n1           (plan_n1),
		.n2           (plan_n2)
	);

	assign ready_s1 = !valid_s2 || st_ready[0];

	// moves with nothing to send are dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1 && (plan_ctl.pend != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			ctl_s2 <= plan_ctl;
			n1_s2  <= plan_n1;
			n2_s2  <= plan_n2;
		end
	end

	assign st_valid[0] = valid_s2;
	assign st_ctl[0]   = ctl_s2;
	assign st_v1[0]    = n1_s2;
	assign st_v2[0]    = n2_s2;
	assign st_dig1[0]  = '0;
	assign st_dig2[0]  = '0;

	for (genvar g = 0; g < NDIG; g++) begin : g_digit
		cmee_digit_stage #(
			.NW  (NW),
			.NDIG(NDIG),
			.POS (g)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (st_valid[g]),
			.in_ready (st_ready[g]),
			.in_ctl   (st_ctl[g]),
			.in_v1    (st_v1[g]),
			.in_v2    (st_v2[g]),
			.in_dig1  (st_dig1[g]),
			.in_dig2  (st_dig2[g]),
			.out_valid(st_valid[g+1]),
			.out_ready(st_ready[g+1]),
			.out_ctl  (st_ctl[g+1]),
			.out_v1   (st_v1[g+1]),
			.out_v2   (st_v2[g+1]),
			.out_dig1 (st_dig1[g+1]),
			.out_dig2 (st_dig2[g+1])
		);
	end

	cmee_serializer #(
		.NDIG(NDIG)
	) u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (st_valid[NDIG]),
		.in_ready  (st_ready[NDIG]),
		.in_ctl    (st_ctl[NDIG]),
		.in_dig1   (st_dig1[NDIG]),
		.in_dig2   (st_dig2[NDIG]),
		.byte_valid(byte_valid),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule

// File: sim/cmee_checker.sv
// predicts the byte stream of each accepted cursor move and compares it with the block output
module cmee_checker #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [COORD_BITS-1:0] cur_row,
	input  logic [COORD_BITS-1:0] cur_col,
	input  logic                  cur_col_known,
	input  logic [COORD_BITS-1:0] want_row,
	input  logic [COORD_BITS-1:0] want_col,
	input  logic                  byte_valid,
	input  logic [7:0]            out_byte,
	input  logic                  last_byte,
	output int                    errors,
	output int                    pending
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] code;
		logic       fin;
	} move_byte_t;

	move_byte_t  move_bytes_q[$];
	logic [7:0]  seq_bytes[$];
	int          n_err  = 0;
	int          n_pend = 0;
	int          n_seen = 0;

	assign errors  = n_err;
	assign pending = n_pend;

	function automatic void add_byte(input logic [7:0] b);
		seq_bytes = {seq_bytes, b};
	endfunction

	function automatic void add_decimal(input int unsigned v);
		logic [7:0] digits[$];
		logic [3:0] d;
		do begin
			d = 4'(v % 10);
			digits.push_front({cmee_pkg::DIGIT_HI, d});
			v = v / 10;
		end while (v != 0);
		foreach (digits[k])
			add_byte(digits[k]);
	endfunction

	function automatic void add_csi(input int unsigned n, input logic [7:0] fin);
		add_byte(cmee_pkg::CH_ESC);
		add_byte(cmee_pkg::CH_LBR);
		add_decimal(n);
		add_byte(fin);
	endfunction

	function automatic void add_reverse_index();
		add_byte(cmee_pkg::CH_ESC);
		add_byte(cmee_pkg::CH_RI);
	endfunction

	// horizontal move on the current row
	function automatic void add_column_move(input int unsigned cc, input logic known,
			input int unsigned wc);
		if (wc == 0)
			add_byte(cmee_pkg::CH_CR);
		else if (!known)
			add_csi(wc + 1, cmee_pkg::FIN_CHA);
		else if (wc + 1 == cc)
			add_byte(cmee_pkg::CH_BS);
		else if (wc < cc)
			add_csi(cc - wc, cmee_pkg::FIN_CUB);
		else
			add_csi(wc - cc, cmee_pkg::FIN_CUF);
	endfunction

	function automatic void predict_move(input int unsigned cr, input int unsigned cc,
			input logic known, input int unsigned wr, input int unsigned wc);
		logic       col_same;
		move_byte_t mb;
		col_same = known && cc == wc;
		seq_bytes.delete();
		if (cr == wr) begin
			if (!col_same)
				add_column_move(cc, known, wc);
		end else if (col_same) begin
			if (wr == cr + 1)
				add_byte(cmee_pkg::CH_LF);
			else if (wr + 1 == cr)
				add_reverse_index();
			else if (wr < cr)
				add_csi(cr - wr, cmee_pkg::FIN_CUU);
			else
				add_csi(wr - cr, cmee_pkg::FIN_CUD);
		end else if (wc == 0) begin
			if (wr == 0) begin
				add_byte(cmee_pkg::CH_ESC);
				add_byte(cmee_pkg::CH_LBR);
				add_byte(cmee_pkg::FIN_CUP);
			end else if (wr == cr + 1) begin
				add_byte(cmee_pkg::CH_CR);
				add_byte(cmee_pkg::CH_LF);
			end else if (wr + 1 == cr) begin
				add_byte(cmee_pkg::CH_CR);
				add_reverse_index();
			end else if (wr < cr) begin
				add_csi(cr - wr, cmee_pkg::FIN_CPL);
			end else begin
				add_csi(wr - cr, cmee_pkg::FIN_CNL);
			end
		end else if (wr == cr + 1) begin
			add_column_move(cc, known, wc);
			add_byte(cmee_pkg::CH_LF);
		end else if (wr + 1 == cr) begin
			add_column_move(cc, known, wc);
			add_reverse_index();
		end else begin
			// absolute position as the fallback
			add_byte(cmee_pkg::CH_ESC);
			add_byte(cmee_pkg::CH_LBR);
			add_decimal(wr + 1);
			add_byte(cmee_pkg::CH_SEMI);
			add_decimal(wc + 1);
			add_byte(cmee_pkg::FIN_CUP);
		end
		foreach (seq_bytes[k]) begin
			mb.code      = seq_bytes[k];
			mb.fin       = (k == seq_bytes.size() - 1);
			move_bytes_q = {move_bytes_q, mb};
		end
	endfunction

	always @(posedge clk) begin
		move_byte_t want;
		if (arst_n) begin
			if ($isunknown(byte_valid)) begin
				n_err++;
				$display("%0t: byte_valid unknown, expected 0 or 1, got %b", $time, byte_valid);
			end else if (byte_valid) begin
				n_seen++;
				if (move_bytes_q.size() == 0) begin
					n_err++;
					$display("%0t: byte %0d expected none, got %h last %b",
						$time, n_seen, out_byte, last_byte);
				end else begin
					want = move_bytes_q.pop_front();
					if (out_byte !== want.code) begin
						n_err++;
						$display("%0t: byte %0d out_byte expected %h, got %h",
							$time, n_seen, want.code, out_byte);
					end
					if (last_byte !== want.fin) begin
						n_err++;
						$display("%0t: byte %0d last_byte expected %b, got %b",
							$time, n_seen, want.fin, last_byte);
					end
				end
			end
			// a move transfer at this edge
			if (start && !busy)
				predict_move(32'(cur_row), 32'(cur_col), cur_col_known,
					32'(want_row), 32'(want_col));
			n_pend = move_bytes_q.size();
		end
	end

endmodule

// File: sim/cursor_move_escape_encoder_core_tb.sv
// stimulus and verdict for the cursor move escape encoder core
module cursor_move_escape_encoder_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS  = 12;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 24;
	localparam int RANDOM_MOVES = 286;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [COORD_BITS-1:0] cur_row;
	logic [COORD_BITS-1:0] cur_col;
	logic                  cur_col_known;
	logic [COORD_BITS-1:0] want_row;
	logic [COORD_BITS-1:0] want_col;
	logic                  byte_valid;
	logic [7:0]            out_byte;
	logic                  last_byte;
	int                    errors;
	int                    pending;
	int                    cycles = 0;
	logic                  burst  = 1'b0;

	cursor_move_escape_encoder_core #(
		.COORD_BITS(COORD_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cur_row(cur_row),
		.cur_col(cur_col),
		.cur_col_known(cur_col_known),
		.want_row(want_row),
		.want_col(want_col),
		.byte_valid(byte_valid),
		.out_byte(out_byte),
		.last_byte(last_byte)
	);

	cmee_checker #(
		.COORD_BITS(COORD_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cur_row(cur_row),
		.cur_col(cur_col),
		.cur_col_known(cur_col_known),
		.want_row(want_row),
		.want_col(want_col),
		.byte_valid(byte_valid),
		.out_byte(out_byte),
		.last_byte(last_byte),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// one move transfer, preceded outside burst mode by a random number of idle cycles
	task automatic send_move(input logic [COORD_BITS-1:0] cr, input logic [COORD_BITS-1:0] cc,
			input logic known, input logic [COORD_BITS-1:0] wr,
			input logic [COORD_BITS-1:0] wc);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cur_row       = cr;
		cur_col       = cc;
		cur_col_known = known;
		want_row      = wr;
		want_col      = wc;
		start         = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	function automatic logic [COORD_BITS-1:0] any_coord();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return COORD_BITS'($urandom_range(0, 15));
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	// target near the current coordinate so the one-step and relative cases come up often
	function automatic logic [COORD_BITS-1:0] near_coord(input logic [COORD_BITS-1:0] base);
		case ($urandom_range(0, 9))
			0, 1: return base;
			2: return base + COORD_BITS'(1);
			3: return base - COORD_BITS'(1);
			4: return base + COORD_BITS'($urandom_range(2, 30));
			5: return base - COORD_BITS'($urandom_range(2, 30));
			6: return '0;
			7: return '1;
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	initial begin
		logic [COORD_BITS-1:0] cr, cc, wr, wc;
		logic                  known;
		arst_n        = 1'b0;
		start         = 1'b0;
		cur_row       = '0;
		cur_col       = '0;
		cur_col_known = 1'b0;
		want_row      = '0;
		want_col      = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// same position, then moves along the row
		send_move(12'd7, 12'd9, 1'b1, 12'd7, 12'd9);
		send_move(12'd7, 12'd9, 1'b1, 12'd7, 12'd0);
		send_move(12'd7, 12'd9, 1'b0, 12'd7, 12'd4095);
		send_move(12'd7, 12'd9, 1'b0, 12'd7, 12'd9);
		send_move(12'd7, 12'd0, 1'b0, 12'd7, 12'd0);
		send_move(12'd7, 12'd9, 1'b1, 12'd7, 12'd8);
		send_move(12'd7, 12'd4095, 1'b1, 12'd7, 12'd1);
		send_move(12'd7, 12'd0, 1'b1, 12'd7, 12'd4095);
		// same known column
		send_move(12'd3, 12'd5, 1'b1, 12'd4, 12'd5);
		send_move(12'd3, 12'd5, 1'b1, 12'd2, 12'd5);
		send_move(12'd4095, 12'd5, 1'b1, 12'd0, 12'd5);
		send_move(12'd0, 12'd4095, 1'b1, 12'd4095, 12'd4095);
		// target column zero
		send_move(12'd5, 12'd7, 1'b1, 12'd0, 12'd0);
		send_move(12'd4095, 12'd7, 1'b0, 12'd0, 12'd0);
		send_move(12'd5, 12'd7, 1'b1, 12'd6, 12'd0);
		send_move(12'd5, 12'd7, 1'b0, 12'd4, 12'd0);
		send_move(12'd50, 12'd7, 1'b1, 12'd3, 12'd0);
		send_move(12'd3, 12'd7, 1'b1, 12'd4000, 12'd0);
		// row step of one with a column change
		send_move(12'd5, 12'd9, 1'b1, 12'd6, 12'd8);
		send_move(12'd5, 12'd9, 1'b0, 12'd4, 12'd30);
		send_move(12'd5, 12'd900, 1'b1, 12'd6, 12'd2);
		send_move(12'd5, 12'd2, 1'b1, 12'd4, 12'd3000);
		// absolute fallback, shortest and longest
		send_move(12'd0, 12'd5, 1'b1, 12'd2, 12'd1);
		send_move(12'd0, 12'd0, 1'b0, 12'd4095, 12'd4095);
		wait_drained();

		for (int i = 0; i < RANDOM_MOVES; i++) begin
			if (i % 40 == 0)
				burst = ($urandom_range(0, 2) == 0);
			if (i == RANDOM_MOVES / 2)
				wait_drained();
			cr    = any_coord();
			cc    = any_coord();
			known = ($urandom_range(0, 4) != 0);
			wr    = near_coord(cr);
			wc    = near_coord(cc);
			send_move(cr, cc, known, wr, wc);
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
